[rtl/wsd_pkg.sv]
// Shared widths and result type for the WebSocket frame deframer.
package wsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned LenW   = 64;
  localparam int unsigned KeyW   = 32;

  // Event codes carried in event_res.
  localparam logic [EventW-1:0] EV_TEXT     = 3'd0;
  localparam logic [EventW-1:0] EV_EMPTY    = 3'd1;
  localparam logic [EventW-1:0] EV_CLOSE    = 3'd2;
  localparam logic [EventW-1:0] EV_UNSUP    = 3'd3;
  localparam logic [EventW-1:0] EV_OVERSIZE = 3'd4;

  // Frame opcodes the parser acts on.
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  payload_byte;
    logic [EventW-1:0] event_res;
    logic              final_fragment;
    logic              end_of_frame;
  } wsd_result_t;

endpackage

[rtl/wsd_if.sv]
// Valid/ready channel interfaces for raw frame bytes and deframed results.
interface wsd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::ByteW-1:0] frame_byte;

  modport source (output valid, output frame_byte, input ready);
  modport sink   (input valid, input frame_byte, output ready);
endinterface

interface wsd_result_if;
  logic                       valid;
  logic                       ready;
  logic [wsd_pkg::ByteW-1:0]  payload_byte;
  logic [wsd_pkg::EventW-1:0] event_res;
  logic                       final_fragment;
  logic                       end_of_frame;

  modport source (output valid, output payload_byte, output event_res,
                  output final_fragment, output end_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input event_res,
                  input final_fragment, input end_of_frame, output ready);
endinterface

[rtl/wsd_parser.sv]
// Frame header state machine, length/key capture and payload unmasking.
module wsd_parser #(
  parameter int unsigned MAX_PAYLOAD = 16384
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [wsd_pkg::ByteW-1:0]  frame_byte,
  input  logic                       forward_enable,
  output wsd_pkg::wsd_result_t       res
);

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_KEY   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;

  localparam logic [wsd_pkg::LenW-1:0] MaxLen = wsd_pkg::LenW'(MAX_PAYLOAD);
  localparam logic [6:0] Len16 = 7'd126;
  localparam logic [6:0] Len64 = 7'd127;

  logic [2:0]                phase_r, phase_nxt;
  logic [3:0]                opc_r, opc_nxt;
  logic                      fin_r, fin_nxt;
  logic                      mask_r, mask_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  // Holds the payload length during the header, then the bytes still to come.
  logic [wsd_pkg::LenW-1:0]  len_r, len_nxt;
  logic [1:0]                kidx_r, kidx_nxt;
  logic [wsd_pkg::KeyW-1:0]  key_r, key_nxt;

  logic                      hd_go;
  logic [wsd_pkg::LenW-1:0]  hd_len;
  logic [wsd_pkg::ByteW-1:0] key_byte;
  logic                      last_byte;

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign last_byte = (len_r <= wsd_pkg::LenW'(1));

  always_comb begin
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    kidx_nxt  = kidx_r;
    key_nxt   = key_r;
    hd_go     = 1'b0;
    hd_len    = len_r;
    res       = '0;
    res.final_fragment = fin_r;

    case (phase_r)
      PH_HDR1: begin
        mask_nxt = frame_byte[7];
        cnt_nxt  = '0;
        if (frame_byte[6:0] == Len16) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT16;
        end else if (frame_byte[6:0] == Len64) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT64;
        end else begin
          len_nxt = wsd_pkg::LenW'(frame_byte[6:0]);
          key_nxt = '0;
          if (frame_byte[7]) begin
            phase_nxt = PH_KEY;
          end else begin
            hd_go  = 1'b1;
            hd_len = len_nxt;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt = {len_r[wsd_pkg::LenW-wsd_pkg::ByteW-1:0], frame_byte};
        cnt_nxt = cnt_r + 3'd1;
        if ((phase_r == PH_EXT16 && cnt_nxt == 3'd2) ||
            (phase_r == PH_EXT64 && cnt_nxt == 3'd0)) begin
          cnt_nxt = '0;
          key_nxt = '0;
          if (mask_r) begin
            phase_nxt = PH_KEY;
          end else begin
            hd_go  = 1'b1;
            hd_len = len_nxt;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[wsd_pkg::KeyW-wsd_pkg::ByteW-1:0], frame_byte};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_nxt == 3'd4) begin
          cnt_nxt = '0;
          hd_go   = 1'b1;
          hd_len  = len_r;
        end
      end
      PH_DATA: begin
        kidx_nxt = kidx_r + 2'd1;
        len_nxt  = len_r - wsd_pkg::LenW'(1);
        res.valid        = forward_enable;
        res.payload_byte = frame_byte ^ key_byte;
        res.event_res    = wsd_pkg::EV_TEXT;
        res.end_of_frame = last_byte;
        if (last_byte) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_SKIP: begin
        len_nxt = len_r - wsd_pkg::LenW'(1);
        if (last_byte) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        fin_nxt   = frame_byte[7];
        opc_nxt   = frame_byte[3:0];
        cnt_nxt   = '0;
        phase_nxt = PH_HDR1;
      end
    endcase

    // Header complete: pick the payload phase and any frame event.
    if (hd_go) begin
      kidx_nxt = '0;
      len_nxt  = hd_len;
      if (hd_len > MaxLen) begin
        phase_nxt        = PH_SKIP;
        res.valid        = forward_enable;
        res.event_res    = wsd_pkg::EV_OVERSIZE;
        res.end_of_frame = 1'b1;
      end else if (opc_r == wsd_pkg::OP_TEXT) begin
        if (hd_len == '0) begin
          phase_nxt        = PH_HDR0;
          res.valid        = forward_enable;
          res.event_res    = wsd_pkg::EV_EMPTY;
          res.end_of_frame = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end else begin
        phase_nxt        = (hd_len != '0) ? PH_SKIP : PH_HDR0;
        res.valid        = forward_enable;
        res.event_res    = (opc_r == wsd_pkg::OP_CLOSE) ? wsd_pkg::EV_CLOSE
                                                        : wsd_pkg::EV_UNSUP;
        res.end_of_frame = 1'b1;
      end
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      opc_r   <= '0;
      fin_r   <= 1'b0;
      mask_r  <= 1'b0;
      cnt_r   <= '0;
      len_r   <= '0;
      kidx_r  <= '0;
      key_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      kidx_r  <= kidx_nxt;
      key_r   <= key_nxt;
    end
  end

endmodule

[rtl/websocket_frame_deframer_core.sv]
// WebSocket client frame deframer: header parse, unmask and event reporting.
//
// Takes client-to-server WebSocket frames one raw byte per request on in_ch
// and gives unmasked text payload bytes and frame events on out_ch. Each
// byte is held in an input register, the header state machine and key XOR
// work on it in one pass, and any result lands in an output register, so a
// byte can be taken every cycle while out_ch.ready is high. A byte in the
// input register is parsed there and any result it gives is registered
// onto out_ch when the parse stage advances. The design has a single parse
// stage; a stall on out_ch only stops it once a result is actually waiting.
// Events: text byte, empty text frame, close, unsupported opcode (any opcode
// other than text or close) and oversize (length above MAX_PAYLOAD, checked
// first); payloads of non-text frames are swallowed. Clearing cfg_wdata via
// cfg_we keeps parsing going but suppresses every result; write it only
// while idle.
module websocket_frame_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  wsd_byte_if.sink      in_ch,
  wsd_result_if.source  out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic                      fwd_en_r;
  logic                      s1_valid_r, s1_valid_nxt;
  logic [wsd_pkg::ByteW-1:0] s1_byte_r;
  logic                      out_valid_r, out_valid_nxt;
  wsd_pkg::wsd_result_t      out_r;
  wsd_pkg::wsd_result_t      res;
  logic                      advance;

  // The parse stage moves on when the output register is free or draining.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b1;
    end else if (cfg_we) begin
      fwd_en_r <= cfg_wdata;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.frame_byte;
    end
  end

  wsd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .frame_byte     (s1_byte_r),
    .forward_enable (fwd_en_r),
    .res            (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.event_res      = out_r.event_res;
  assign out_ch.final_fragment = out_r.final_fragment;
  assign out_ch.end_of_frame   = out_r.end_of_frame;

endmodule

[tb/sv/tb_websocket_frame_deframer_core.sv]
// Self-checking testbench for websocket_frame_deframer_core.
module tb_websocket_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPayload  = 16384;
  // A request's result reaches out_ch once the parse stage advances on it;
  // allow slack.
  localparam int unsigned DrainCycles = 6;

  // Frame opcodes used by name in the stimulus.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;
  localparam logic [3:0] OP_RSVD  = 4'hF;

  // Escape codes in the 7-bit length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_KEY, PH_DATA, PH_SKIP
  } parse_phase_e;

  typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;

  typedef struct packed {
    logic [wsd_pkg::ByteW-1:0]  payload_byte;
    logic [wsd_pkg::EventW-1:0] event_res;
    logic                       final_fragment;
    logic                       end_of_frame;
  } deframed_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  wsd_byte_if   in_ch();
  wsd_result_if out_ch();

  websocket_frame_deframer_core #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 2 ns period, starts low so nothing races the first edge.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Raw stream waiting to be sent, and results owed by the block.
  logic [wsd_pkg::ByteW-1:0] wire_bytes[$];
  deframed_t                 awaited_results[$];

  int unsigned fault_count  = 0;
  int unsigned in_gap_max   = 0;
  int unsigned out_stall_max = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;

  // ---------------------------------------------------------------------
  // Deframer predictor: its own copy of the parse state and of the
  // forwarding switch, stepped once per accepted request.
  // ---------------------------------------------------------------------
  logic         fwd_en     = 1'b1;
  parse_phase_e rx_phase   = PH_HDR0;
  logic [3:0]   rx_opcode  = '0;
  logic         rx_fin     = 1'b0;
  logic         rx_masked  = 1'b0;
  logic [2:0]   rx_hdr_cnt = '0;
  logic [wsd_pkg::LenW-1:0] rx_len = '0;
  logic [wsd_pkg::LenW-1:0] rx_idx = '0;
  logic [wsd_pkg::KeyW-1:0] rx_key = '0;

  // Header finished: the size check wins over everything, then the opcode
  // decides between streaming text and a single event with a silent skip.
  function automatic bit header_complete(output deframed_t r);
    logic [wsd_pkg::EventW-1:0] ev;
    r      = '0;
    rx_idx = '0;
    if (rx_len > wsd_pkg::LenW'(MaxPayload)) begin
      ev = wsd_pkg::EV_OVERSIZE;
    end else if (rx_opcode == wsd_pkg::OP_TEXT) begin
      if (rx_len == '0) begin
        rx_phase = PH_HDR0;
        r = '{8'h00, wsd_pkg::EV_EMPTY, rx_fin, 1'b1};
        return fwd_en;
      end
      rx_phase = PH_DATA;
      return 1'b0;
    end else if (rx_opcode == wsd_pkg::OP_CLOSE) begin
      ev = wsd_pkg::EV_CLOSE;
    end else begin
      ev = wsd_pkg::EV_UNSUP;
    end
    rx_phase = (rx_len != '0) ? PH_SKIP : PH_HDR0;
    r = '{8'h00, ev, rx_fin, 1'b1};
    return fwd_en;
  endfunction

  // Length known: fetch the key if the mask bit was set, else header is done.
  function automatic bit length_complete(output deframed_t r);
    r          = '0;
    rx_hdr_cnt = '0;
    rx_key     = '0;
    if (rx_masked) begin
      rx_phase = PH_KEY;
      return 1'b0;
    end
    return header_complete(r);
  endfunction

  function automatic bit deframe_byte(input logic [wsd_pkg::ByteW-1:0] b,
                                      output deframed_t r);
    logic [6:0]                len7;
    logic [wsd_pkg::ByteW-1:0] kb;
    int                        lane;
    r = '0;
    case (rx_phase)
      PH_HDR1: begin
        rx_masked  = b[7];
        len7       = b[6:0];
        rx_len     = '0;
        rx_hdr_cnt = '0;
        if (len7 == LEN_EXT16) begin
          rx_phase = PH_EXT16;
          return 1'b0;
        end
        if (len7 == LEN_EXT64) begin
          rx_phase = PH_EXT64;
          return 1'b0;
        end
        rx_len = wsd_pkg::LenW'(len7);
        return length_complete(r);
      end
      PH_EXT16, PH_EXT64: begin
        // big-endian, all 64 bits kept (top bit not policed)
        rx_len     = {rx_len[wsd_pkg::LenW-9:0], b};
        rx_hdr_cnt = rx_hdr_cnt + 3'd1;
        if ((rx_phase == PH_EXT16 && rx_hdr_cnt == 3'd2) ||
            (rx_phase == PH_EXT64 && rx_hdr_cnt == 3'd0))
          return length_complete(r);
        return 1'b0;
      end
      PH_KEY: begin
        rx_key     = {rx_key[wsd_pkg::KeyW-9:0], b};
        rx_hdr_cnt = rx_hdr_cnt + 3'd1;
        if (rx_hdr_cnt == 3'd4) begin
          rx_hdr_cnt = '0;
          return header_complete(r);
        end
        return 1'b0;
      end
      PH_DATA: begin
        // key bytes cycle from the most significant one
        lane   = 3 - int'(rx_idx[1:0]);
        kb     = rx_key[8*lane +: 8];
        rx_idx = rx_idx + 1;
        r = '{b ^ kb, wsd_pkg::EV_TEXT, rx_fin, rx_idx >= rx_len};
        if (rx_idx >= rx_len)
          rx_phase = PH_HDR0;
        return fwd_en;
      end
      PH_SKIP: begin
        rx_idx = rx_idx + 1;
        if (rx_idx >= rx_len)
          rx_phase = PH_HDR0;
        return 1'b0;
      end
      default: begin
        // RSV1..3 ignored
        rx_fin     = b[7];
        rx_opcode  = b[3:0];
        rx_hdr_cnt = '0;
        rx_phase   = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: pops the raw stream, inserts a random gap after each
  // byte, and feeds every accepted byte to the predictor.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drv_b
    deframed_t r;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.frame_byte <= '0;
      gap_left         <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (deframe_byte(in_ch.frame_byte, r))
          awaited_results.push_back(r);
      end
      // slot is free once the current request has gone or none is up
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (wire_bytes.size() != 0) begin
          in_ch.valid      <= 1'b1;
          in_ch.frame_byte <= wire_bytes.pop_front();
          gap_left         <= $urandom_range(0, in_gap_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest
  // prediction, then holds ready low for a random stall.
  // ---------------------------------------------------------------------
  task automatic check_result();
    deframed_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: payload_byte %02h event_res %0d final_fragment %0b end_of_frame %0b",
             out_ch.payload_byte, out_ch.event_res, out_ch.final_fragment,
             out_ch.end_of_frame);
      fault_count++;
      return;
    end
    want = awaited_results.pop_front();
    if (out_ch.payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %02h actual %02h", want.payload_byte, out_ch.payload_byte);
      fault_count++;
    end
    if (out_ch.event_res !== want.event_res) begin
      $error("event_res: expected %0d actual %0d", want.event_res, out_ch.event_res);
      fault_count++;
    end
    if (out_ch.final_fragment !== want.final_fragment) begin
      $error("final_fragment: expected %0b actual %0b", want.final_fragment,
             out_ch.final_fragment);
      fault_count++;
    end
    if (out_ch.end_of_frame !== want.end_of_frame) begin
      $error("end_of_frame: expected %0b actual %0b", want.end_of_frame, out_ch.end_of_frame);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : mon_b
    int unsigned hold;
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      check_result();
      hold = $urandom_range(0, out_stall_max);
      stall_left   <= hold;
      out_ch.ready <= (hold == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------
  // fill < 0 gives random bytes, else a constant byte
  task automatic queue_payload(input int unsigned n, input int fill);
    repeat (n)
      wire_bytes.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  // Header plus 'body' payload bytes; body may differ from len on purpose.
  task automatic queue_frame(input logic fin_b, input logic [2:0] rsv, input logic [3:0] opc,
                             input logic masked, input len_form_e form,
                             input logic [wsd_pkg::LenW-1:0] len,
                             input logic [wsd_pkg::KeyW-1:0] mkey,
                             input int unsigned body, input int fill);
    wire_bytes.push_back({fin_b, rsv, opc});
    case (form)
      FORM_SHORT: wire_bytes.push_back({masked, len[6:0]});
      FORM_EXT16: begin
        wire_bytes.push_back({masked, LEN_EXT16});
        wire_bytes.push_back(len[15:8]);
        wire_bytes.push_back(len[7:0]);
      end
      default: begin
        wire_bytes.push_back({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--)
          wire_bytes.push_back(len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--)
        wire_bytes.push_back(mkey[8*i +: 8]);
    end
    queue_payload(body, fill);
  endtask

  // Mostly well-formed text traffic with random content; the rest binary,
  // control, reserved or continuation frames, unmasked frames, odd RSV bits and
  // non-minimal length encodings.
  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned n;
    logic [3:0]  opc;
    len_form_e   form;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      opc = wsd_pkg::OP_TEXT;
    else if (pick < 72)
      opc = wsd_pkg::OP_CLOSE;
    else
      opc = 4'($urandom_range(0, 15));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
    pick = $urandom_range(0, 9);
    if (pick < 7)
      form = FORM_SHORT;
    else if (pick < 9)
      form = FORM_EXT16;
    else
      form = FORM_EXT64;
    queue_frame(1'($urandom_range(0, 1)),
                ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0,
                opc, $urandom_range(0, 5) != 0, form, wsd_pkg::LenW'(n), $urandom, n, -1);
  endtask

  // Wait until the stream is sent and every owed result is in, then let
  // trailing no-result requests clear the parse stage.
  task automatic drain();
    while (wire_bytes.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_forward(input logic en);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    fwd_en     = en;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = '0;
    out_ch.ready     = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_forward(1'b1);

    // Directed frames, gaps on both sides.
    in_gap_max    = 6;
    out_stall_max = 6;
    // empty text frame
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, FORM_SHORT, 0, 32'hDEAD_BEEF, 0, -1);
    // extreme payload bytes against an all-ones key and a mixed key
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, FORM_SHORT, 4, 32'hFFFF_FFFF, 4, 8'hFF);
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, FORM_SHORT, 5, 32'hFF00_A55A, 5, 8'h00);
    // unmasked, FIN clear, reserved bits set: bytes pass straight through
    queue_frame(1'b0, 3'b111, wsd_pkg::OP_TEXT, 1'b0, FORM_SHORT, 3, '0, 3, -1);
    // close with and without payload
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b1, FORM_SHORT, 2, $urandom, 2, -1);
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_CLOSE, 1'b0, FORM_SHORT, 0, '0, 0, -1);
    // continuation, binary, ping, pong and a reserved opcode: all unsupported
    queue_frame(1'b0, 3'd0, OP_CONT, 1'b1, FORM_SHORT, 0, $urandom, 0, -1);
    queue_frame(1'b1, 3'd0, OP_BIN, 1'b0, FORM_SHORT, 2, '0, 2, -1);
    queue_frame(1'b1, 3'd0, OP_PING, 1'b1, FORM_SHORT, 1, $urandom, 1, -1);
    queue_frame(1'b1, 3'd0, OP_PONG, 1'b0, FORM_SHORT, 0, '0, 0, -1);
    queue_frame(1'b0, 3'd0, OP_RSVD, 1'b1, FORM_SHORT, 1, $urandom, 1, -1);
    // short lengths carried in the 16-bit and 64-bit forms
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, FORM_EXT16, 3, $urandom, 3, -1);
    queue_frame(1'b0, 3'd0, wsd_pkg::OP_TEXT, 1'b0, FORM_EXT64, 2, '0, 2, -1);
    drain();

    // One text frame spread over a disabled window: only the bytes sent
    // while disabled go missing.
    in_gap_max    = 3;
    out_stall_max = 3;
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, FORM_SHORT, 10, $urandom, 4, -1);
    drain();
    write_forward(1'b0);
    queue_payload(3, -1);
    drain();
    write_forward(1'b1);
    queue_payload(3, -1);
    drain();

    // Random traffic in blocks, varying idling and the forwarding switch.
    for (int blk = 0; blk < 6; blk++) begin
      case (blk % 3)
        0:       in_gap_max = 6;
        1:       in_gap_max = 0;
        default: in_gap_max = 2;
      endcase
      out_stall_max = (blk % 2 == 0) ? 0 : 6;
      write_forward((blk == 3) ? 1'b0 : 1'b1);
      while (wire_bytes.size() < 185)
        queue_random_frame();
      drain();
    end

    // Last: a text frame one byte over the size limit, carried in the 64-bit
    // form. Oversize event, then the block sits skipping for good.
    write_forward(1'b1);
    in_gap_max    = 6;
    out_stall_max = 6;
    queue_frame(1'b1, 3'd0, wsd_pkg::OP_TEXT, 1'b1, FORM_EXT64,
                wsd_pkg::LenW'(MaxPayload + 1), $urandom, 0, -1);
    drain();
    repeat (20) @(posedge clk);

    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
